/* rtl/stepper_full_step_sequencer_core_defines.svh */
// ----------------------------------------------------------------------------
// Stepper full-step sequencer assertion macros
// Shared concurrent assertion forms for the sequencer checkers.
// ----------------------------------------------------------------------------
`ifndef STEPPER_FULL_STEP_SEQUENCER_CORE_DEFINES_SVH
`define STEPPER_FULL_STEP_SEQUENCER_CORE_DEFINES_SVH

// Checked only outside reset.
`define SFSS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked at every edge, reset included.
`define SFSS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/sfss_pkg.sv */
// ----------------------------------------------------------------------------
// Stepper full-step sequencer package
// Shared types, register codes and the coil pattern table.
// ----------------------------------------------------------------------------
package sfss_pkg;

  localparam int unsigned FieldBits = 16;
  localparam int unsigned TimeBits  = 32;
  localparam int unsigned CfgIdxBits = 2;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_STEP_THRESHOLD   = 2'd0,
    CFG_START_PRELOAD    = 2'd1,
    CFG_INVERT_DIRECTION = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    REQ_TICK  = 1'b0,
    REQ_START = 1'b1
  } req_type_e;

  localparam logic [FieldBits-1:0] StepThresholdReset = 16'd10;
  localparam logic [FieldBits-1:0] StartPreloadReset  = 16'd10;

  typedef struct packed {
    logic [FieldBits-1:0] step_threshold;
    logic [FieldBits-1:0] start_preload;
    logic                 invert_direction;
  } cfg_t;

  typedef struct packed {
    logic                 req_type;
    logic [FieldBits-1:0] move_steps;
    logic                 move_ccw;
  } req_t;

  typedef struct packed {
    logic [3:0]          coils;
    logic                moving;
    logic                stepped;
    logic [TimeBits-1:0] move_time;
  } rsp_t;

  function automatic logic [3:0] coil_for_phase(input logic [1:0] phase);
    logic [3:0] pattern;
    case (phase)
      2'd0:    pattern = 4'hC;
      2'd1:    pattern = 4'h9;
      2'd2:    pattern = 4'h3;
      default: pattern = 4'h6;
    endcase
    return pattern;
  endfunction

endpackage

/* rtl/sfss_if.sv */
// ----------------------------------------------------------------------------
// Stepper full-step sequencer channels
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface sfss_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [15:0] move_steps;
  logic        move_ccw;

  modport source (output valid, req_type, move_steps, move_ccw, input ready);
  modport sink   (input valid, req_type, move_steps, move_ccw, output ready);
endinterface

interface sfss_rsp_if;
  logic        valid;
  logic        ready;
  logic [3:0]  coils;
  logic        moving;
  logic        stepped;
  logic [31:0] move_time;

  modport source (output valid, coils, moving, stepped, move_time, input ready);
  modport sink   (input valid, coils, moving, stepped, move_time, output ready);
endinterface

/* rtl/sfss_step_unit.sv */
// ----------------------------------------------------------------------------
// Stepper full-step sequencer step unit
// Holds the move state and works out one beat's result and next state.
// ----------------------------------------------------------------------------
module sfss_step_unit
  import sfss_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  req_t req_i,
  input  cfg_t cfg_i,
  output rsp_t rsp_o
);

  localparam int unsigned CmpBits = (COUNT_BITS > FieldBits) ? COUNT_BITS : FieldBits;

  logic [COUNT_BITS-1:0] target_q, target_d;
  logic [COUNT_BITS-1:0] done_q, done_d;
  logic [COUNT_BITS-1:0] icnt_q, icnt_d;
  logic [1:0]            phase_q, phase_d;
  logic                  dir_q, dir_d;
  logic [3:0]            coil_q, coil_d;

  logic [CmpBits-1:0]  steps_ext;
  logic [CmpBits-1:0]  preload_ext;
  logic                stepped;
  logic [TimeBits-1:0] move_time;

  assign steps_ext   = CmpBits'(req_i.move_steps);
  assign preload_ext = CmpBits'(cfg_i.start_preload);

  always_comb begin
    target_d  = target_q;
    done_d    = done_q;
    icnt_d    = icnt_q;
    phase_d   = phase_q;
    dir_d     = dir_q;
    coil_d    = coil_q;
    stepped   = 1'b0;
    move_time = '0;
    if (req_i.req_type == REQ_START) begin
      target_d  = steps_ext[COUNT_BITS-1:0];
      dir_d     = req_i.move_ccw;
      done_d    = '0;
      icnt_d    = preload_ext[COUNT_BITS-1:0];
      move_time = {16'd0, req_i.move_steps} * {16'd0, cfg_i.start_preload};
    end else if (done_q < target_q) begin
      if (CmpBits'(icnt_q) >= CmpBits'(cfg_i.step_threshold)) begin
        icnt_d  = '0;
        done_d  = done_q + COUNT_BITS'(1);
        coil_d  = coil_for_phase(phase_q);
        phase_d = (dir_q ^ cfg_i.invert_direction) ? phase_q + 2'd1 : phase_q - 2'd1;
        stepped = 1'b1;
      end else if (icnt_q != '1) begin
        icnt_d = icnt_q + COUNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
      done_q   <= '0;
      icnt_q   <= '0;
      phase_q  <= '0;
      dir_q    <= 1'b0;
      coil_q   <= '0;
    end else if (en_i) begin
      target_q <= target_d;
      done_q   <= done_d;
      icnt_q   <= icnt_d;
      phase_q  <= phase_d;
      dir_q    <= dir_d;
      coil_q   <= coil_d;
    end
  end

  assign rsp_o.coils     = coil_d;
  assign rsp_o.moving    = done_d < target_d;
  assign rsp_o.stepped   = stepped;
  assign rsp_o.move_time = move_time;

endmodule

/* rtl/stepper_full_step_sequencer_core.sv */
// ----------------------------------------------------------------------------
// Stepper full-step sequencer core
// Two-coils-on full-step sequencer for a four-wire stepper motor.
// ----------------------------------------------------------------------------
// The request channel carries start beats, which load a step target and a
// direction, and tick beats from a timer, which advance the interval counter
// and step the motor when the threshold is reached.
// Every request beat yields exactly one response beat with the coil drive,
// the moving and stepped flags and, for a start, the move time.
// A beat is registered on entry and its result is registered on exit, so a
// request passes through the entry register and then the exit register.
// One request is accepted per cycle unless the response stalls; the move
// state follows the counter compare and the move time is a 16 by 16 product.
// When the receiver stalls, the response holds and the entry register still
// takes one more beat if it is empty; then the request ready drops until the
// response is taken.
// Reset returns the configuration, the valid flags and the move state to their
// defaults, with all coils low. The user must use the configuration port only
// while the core is idle; the core itself does not enforce this.
// ----------------------------------------------------------------------------
module stepper_full_step_sequencer_core
  import sfss_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  sfss_req_if.sink              req_i,
  sfss_rsp_if.source            rsp_o,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxBits-1:0] cfg_idx_i,
  input  logic [FieldBits-1:0]  cfg_data_i
);

  cfg_t cfg_q;
  logic s1_valid_q;
  req_t s1_req_q;
  logic rsp_valid_q;
  rsp_t rsp_q;
  rsp_t rsp_d;
  logic advance;
  logic step_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_threshold   <= StepThresholdReset;
      cfg_q.start_preload    <= StartPreloadReset;
      cfg_q.invert_direction <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_STEP_THRESHOLD:   cfg_q.step_threshold   <= cfg_data_i;
        CFG_START_PRELOAD:    cfg_q.start_preload    <= cfg_data_i;
        CFG_INVERT_DIRECTION: cfg_q.invert_direction <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign advance     = !rsp_valid_q || rsp_o.ready;
  assign req_i.ready = !s1_valid_q || advance;
  assign step_en     = s1_valid_q && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      s1_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      s1_req_q.req_type   <= req_i.req_type;
      s1_req_q.move_steps <= req_i.move_steps;
      s1_req_q.move_ccw   <= req_i.move_ccw;
    end
  end

  sfss_step_unit #(
    .COUNT_BITS(COUNT_BITS)
  ) u_step (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (step_en),
    .req_i (s1_req_q),
    .cfg_i (cfg_q),
    .rsp_o (rsp_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (advance) begin
      rsp_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_en) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.coils     = rsp_q.coils;
  assign rsp_o.moving    = rsp_q.moving;
  assign rsp_o.stepped   = rsp_q.stepped;
  assign rsp_o.move_time = rsp_q.move_time;

endmodule

/* rtl/sfss_checker.sv */
// ----------------------------------------------------------------------------
// Stepper full-step sequencer checker
// Port-level assertions on the response channel, bound to the core.
// ----------------------------------------------------------------------------
`include "stepper_full_step_sequencer_core_defines.svh"

module sfss_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic [3:0]  rsp_coils_i,
  input logic        rsp_moving_i,
  input logic        rsp_stepped_i,
  input logic [31:0] rsp_move_time_i
);

  `SFSS_ASSERT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable({rsp_coils_i, rsp_moving_i, rsp_stepped_i, rsp_move_time_i}), "Stalled response beat changed.")

  `SFSS_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !rsp_valid_i, "Response valid during reset.")

  `SFSS_ASSERT(a_step_no_time, clk_i, rst_ni, rsp_valid_i && rsp_stepped_i |-> rsp_move_time_i == 32'd0, "Stepped beat carries a move time.")

  `SFSS_ASSERT(a_step_coils, clk_i, rst_ni, rsp_valid_i && rsp_stepped_i |-> $countones(rsp_coils_i) == 2, "Step drives a coil pattern without two coils on.")

endmodule

bind stepper_full_step_sequencer_core sfss_checker u_sfss_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .rsp_coils_i    (rsp_o.coils),
  .rsp_moving_i   (rsp_o.moving),
  .rsp_stepped_i  (rsp_o.stepped),
  .rsp_move_time_i(rsp_o.move_time)
);

/* sim/sfss_move_scoreboard_pkg.sv */
// ----------------------------------------------------------------------------
// Stepper sequencer move scoreboard
// Tracks the sequencer's move state for every accepted request beat and
// compares each response beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
package sfss_move_scoreboard_pkg;
  import sfss_pkg::*;

  localparam int unsigned CountBits = 16;
  localparam int unsigned MaxPrinted = 50;

  class sfss_move_scoreboard;
    cfg_t                 cfg;
    logic [CountBits-1:0] target_steps;
    logic [CountBits-1:0] steps_done;
    logic [CountBits-1:0] interval_count;
    logic [1:0]           phase;
    logic                 dir_ccw;
    logic [3:0]           coil_drive;
    rsp_t                 move_rsp_q[$];
    int unsigned          mismatches;
    int unsigned          responses;
    int unsigned          starts;
    int unsigned          ticks;
    int unsigned          steps_taken;

    function new();
      cfg.step_threshold   = StepThresholdReset;
      cfg.start_preload    = StartPreloadReset;
      cfg.invert_direction = 1'b0;
      target_steps         = '0;
      steps_done           = '0;
      interval_count       = '0;
      phase                = 2'd0;
      dir_ccw              = 1'b0;
      coil_drive           = 4'h0;
      mismatches           = 0;
      responses            = 0;
      starts               = 0;
      ticks                = 0;
      steps_taken          = 0;
    endfunction

    function void write_register(logic [CfgIdxBits-1:0] idx, logic [FieldBits-1:0] data);
      case (idx)
        CFG_STEP_THRESHOLD:   cfg.step_threshold = data;
        CFG_START_PRELOAD:    cfg.start_preload = data;
        CFG_INVERT_DIRECTION: cfg.invert_direction = data[0];
        default: ;
      endcase
    endfunction

    function logic [3:0] drive_pattern(logic [1:0] ph);
      logic [3:0] pat;
      case (ph)
        2'd0:    pat = 4'b1100;
        2'd1:    pat = 4'b1001;
        2'd2:    pat = 4'b0011;
        default: pat = 4'b0110;
      endcase
      return pat;
    endfunction

    function void note_request(req_t r);
      rsp_t exp;
      exp = '0;
      if (r.req_type == REQ_START) begin
        starts++;
        target_steps   = r.move_steps[CountBits-1:0];
        dir_ccw        = r.move_ccw;
        steps_done     = '0;
        interval_count = cfg.start_preload[CountBits-1:0];
        exp.move_time  = 32'(r.move_steps) * 32'(cfg.start_preload);
      end else begin
        ticks++;
        if (steps_done < target_steps) begin
          if (32'(interval_count) >= 32'(cfg.step_threshold)) begin
            interval_count = '0;
            steps_done     = steps_done + 1'b1;
            coil_drive     = drive_pattern(phase);
            phase          = (dir_ccw ^ cfg.invert_direction) ? phase + 2'd1 : phase - 2'd1;
            exp.stepped    = 1'b1;
            steps_taken++;
          end else if (interval_count != '1) begin
            interval_count = interval_count + 1'b1;
          end
        end
      end
      exp.coils  = coil_drive;
      exp.moving = (steps_done < target_steps);
      move_rsp_q.push_back(exp);
    endfunction

    function int unsigned pending();
      return move_rsp_q.size();
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      if (mismatches <= MaxPrinted) begin
        $display("[%0t] mismatch on %s at response %0d: got 0x%0h, expected 0x%0h",
                 $time, what, responses, got, want);
      end
    endtask

    task check_response(rsp_t got);
      rsp_t want;
      responses++;
      if (move_rsp_q.size() == 0) begin
        report_mismatch("unexpected beat", 32'(got.coils), 32'h0);
      end else begin
        want = move_rsp_q.pop_front();
        if (got.coils !== want.coils) report_mismatch("coils", 32'(got.coils), 32'(want.coils));
        if (got.moving !== want.moving) begin
          report_mismatch("moving", 32'(got.moving), 32'(want.moving));
        end
        if (got.stepped !== want.stepped) begin
          report_mismatch("stepped", 32'(got.stepped), 32'(want.stepped));
        end
        if (got.move_time !== want.move_time) begin
          report_mismatch("move_time", got.move_time, want.move_time);
        end
      end
    endtask

    task check_leftover();
      while (move_rsp_q.size() != 0) begin
        report_mismatch("missing beat", 32'(move_rsp_q[0].coils), 32'(move_rsp_q[0].move_time));
        void'(move_rsp_q.pop_front());
      end
    endtask
  endclass

endpackage

/* sim/tb_stepper_full_step_sequencer_core.sv */
// ----------------------------------------------------------------------------
// Stepper full-step sequencer core testbench
// Drives start and tick beats through directed corner moves and random move
// sequences under several register settings, with random gaps and stalls on
// both channels, and checks every response beat against a move tracker.
// ----------------------------------------------------------------------------
module tb_stepper_full_step_sequencer_core;
  timeunit 1ns;
  timeprecision 1ps;

  import sfss_pkg::*;
  import sfss_move_scoreboard_pkg::*;

  localparam int unsigned CycleLimit  = 600000;
  localparam int unsigned DrainCycles = 8;
  localparam logic [CfgIdxBits-1:0] CfgIdxUnused = 2'd3;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CfgIdxBits-1:0] cfg_idx;
  logic [FieldBits-1:0]  cfg_data;

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned settings_run;

  sfss_move_scoreboard moves;

  sfss_req_if req_if ();
  sfss_rsp_if rsp_if ();

  stepper_full_step_sequencer_core #(
    .COUNT_BITS(CountBits)
  ) i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_if),
    .rsp_o     (rsp_if),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  always #5 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    rsp_if.ready = ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin : monitor
    rsp_t got;
    if (rst_ni === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      got.coils     = rsp_if.coils;
      got.moving    = rsp_if.moving;
      got.stepped   = rsp_if.stepped;
      got.move_time = rsp_if.move_time;
      moves.check_response(got);
    end
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("Timed out after %0d cycles with %0d beats outstanding.",
             CycleLimit, moves.pending());
    $display("CHECK FAILED");
    $finish;
  end

  function automatic req_t start_beat(logic [FieldBits-1:0] steps, logic ccw);
    req_t r;
    r.req_type   = REQ_START;
    r.move_steps = steps;
    r.move_ccw   = ccw;
    return r;
  endfunction

  function automatic req_t tick_beat();
    req_t r;
    r.req_type   = REQ_TICK;
    r.move_steps = 16'($urandom);
    r.move_ccw   = 1'($urandom);
    return r;
  endfunction

  task automatic send_request(input req_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_if.valid = 1'b0;
      @(negedge clk_i);
    end
    req_if.valid      = 1'b1;
    req_if.req_type   = r.req_type;
    req_if.move_steps = r.move_steps;
    req_if.move_ccw   = r.move_ccw;
    @(posedge clk_i);
    while (req_if.ready !== 1'b1) @(posedge clk_i);
    moves.note_request(r);
    @(negedge clk_i);
  endtask

  task automatic send_ticks(input int unsigned n);
    repeat (n) send_request(tick_beat());
  endtask

  task automatic wait_drained();
    req_if.valid = 1'b0;
    while (moves.pending() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_register(input logic [CfgIdxBits-1:0] idx,
                                input logic [FieldBits-1:0] data);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = data;
    @(negedge clk_i);
    cfg_we = 1'b0;
    moves.write_register(idx, data);
  endtask

  task automatic configure(input logic [FieldBits-1:0] threshold,
                           input logic [FieldBits-1:0] preload,
                           input logic invert);
    wait_drained();
    write_register(CFG_STEP_THRESHOLD, threshold);
    write_register(CFG_START_PRELOAD, preload);
    write_register(CFG_INVERT_DIRECTION, {15'($urandom), invert});
    settings_run++;
  endtask

  task automatic run_moves(input int unsigned budget, input bit pause_midway);
    int unsigned sent;
    int unsigned n_ticks;
    bit          paused;
    logic [FieldBits-1:0] steps;
    sent   = 0;
    paused = 1'b0;
    while (sent < budget) begin
      if (pause_midway && !paused && sent >= budget / 2) begin
        paused = 1'b1;
        wait_drained();
      end
      if ($urandom_range(0, 99) < 80) begin
        steps = ($urandom_range(0, 15) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
        send_request(start_beat(steps, 1'($urandom)));
        sent++;
        n_ticks = 32'(steps) * (32'(moves.cfg.step_threshold) + 1) + $urandom_range(0, 4);
        if (n_ticks > budget - sent) n_ticks = budget - sent;
        send_ticks(n_ticks);
        sent += n_ticks;
      end else begin
        repeat ($urandom_range(1, 5)) begin
          if ($urandom_range(0, 1) == 1) begin
            send_request(start_beat(16'($urandom), 1'($urandom)));
          end else begin
            send_request(tick_beat());
          end
          sent++;
        end
      end
    end
  endtask

  initial begin
    clk_i             = 1'b0;
    rst_ni            = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = CFG_STEP_THRESHOLD;
    cfg_data          = '0;
    req_if.valid      = 1'b0;
    req_if.req_type   = REQ_TICK;
    req_if.move_steps = '0;
    req_if.move_ccw   = 1'b0;
    rsp_if.ready      = 1'b1;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    settings_run      = 1;
    moves             = new();

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    // Reset settings: idle ticks, an empty move, and coils held across a start.
    send_request(tick_beat());
    send_request(start_beat(16'd0, 1'b1));
    send_request(tick_beat());
    send_request(start_beat(16'hFFFF, 1'b1));
    send_ticks(2);
    send_request(start_beat(16'd2, 1'b0));
    send_ticks(4);

    // Zero threshold with the largest preload and the direction inverted.
    configure(16'd0, 16'hFFFF, 1'b1);
    send_request(start_beat(16'hFFFF, 1'b0));
    send_ticks(4);
    send_request(start_beat(16'd3, 1'b1));
    send_ticks(5);

    // Largest threshold: the counter climbs to its top before the one step.
    configure(16'hFFFF, 16'hFFFE, 1'b0);
    write_register(CfgIdxUnused, 16'($urandom));
    send_request(start_beat(16'd1, 1'b1));
    send_ticks(3);

    configure(16'd0, 16'd0, 1'b0);
    run_moves(300, 1'b0);

    send_idle_pct = 57;
    configure(16'd3, 16'd1, 1'b1);
    run_moves(300, 1'b0);

    send_idle_pct  = 0;
    recv_stall_pct = 57;
    configure(16'd1, 16'hFFFF, 1'b0);
    run_moves(300, 1'b0);

    send_idle_pct  = 14;
    recv_stall_pct = 14;
    configure(16'd2, 16'($urandom), 1'($urandom));
    write_register(CfgIdxUnused, 16'($urandom));
    run_moves(300, 1'b0);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    configure(16'($urandom_range(0, 7)), 16'($urandom_range(0, 7)), 1'($urandom));
    run_moves(250, 1'b1);

    send_idle_pct  = 14;
    recv_stall_pct = 14;
    configure(16'hFFFF, 16'hFFFF, 1'b1);
    run_moves(40, 1'b0);

    send_idle_pct  = 57;
    recv_stall_pct = 0;
    configure(16'd5, 16'd0, 1'b0);
    run_moves(250, 1'b0);

    send_idle_pct  = 0;
    recv_stall_pct = 57;
    configure(16'($urandom_range(0, 4)), 16'($urandom), 1'($urandom));
    run_moves(300, 1'b0);

    wait_drained();
    repeat (20) @(posedge clk_i);
    moves.check_leftover();

    $display("Covered %0d starts and %0d ticks giving %0d steps over %0d register settings,",
             moves.starts, moves.ticks, moves.steps_taken, settings_run);
    $display("with gaps and stalls on both channels; %0d responses, %0d mismatches.",
             moves.responses, moves.mismatches);
    if (moves.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* stepper_full_step_sequencer_core.f */
+incdir+rtl
rtl/sfss_pkg.sv
rtl/sfss_if.sv
rtl/sfss_step_unit.sv
rtl/stepper_full_step_sequencer_core.sv
rtl/sfss_checker.sv
sim/sfss_move_scoreboard_pkg.sv
sim/tb_stepper_full_step_sequencer_core.sv
